/* rtl/plsb_pkg.sv */
// Package for the palette lookup block: word types, operation codes and
// color helpers. No dependencies.
`default_nettype none

package plsb_pkg;

    localparam int OFF_MAX_W   = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_CONVERT = 2'd1;
    localparam logic [1:0] FUNC_SHADE   = 2'd2;

    localparam logic [1:0] BANK_NORMAL    = 2'd0;
    localparam logic [1:0] BANK_SHADOW    = 2'd1;
    localparam logic [1:0] BANK_HIGHLIGHT = 2'd2;

    localparam logic [11:0] SHADE_MUL = 12'd202;

    typedef struct packed {
        logic [1:0]  func;
        logic [13:0] pal_byte_addr;
        logic [4:0]  red;
        logic [4:0]  green;
        logic [4:0]  blue;
        logic [31:0] selector_pair;
        logic [15:0] color_in;
        logic        last_pair;
    } item_word_t;

    typedef struct packed {
        logic [31:0] pixel_pair;
        logic        pair_last;
    } result_word_t;

    typedef struct packed {
        logic                 hit;
        logic [1:0]           bank;
        logic [OFF_MAX_W-1:0] off;
    } lane_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [OFF_MAX_W-1:0] wr_off;
        logic [15:0]          normal;
        logic [15:0]          shadow;
        lane_t                lane0;
        lane_t                lane1;
        logic                 last;
    } op_t;

    function automatic logic [15:0] swap16(input logic [15:0] c);
        return {c[7:0], c[15:8]};
    endfunction

    function automatic logic [15:0] to_order(input logic [15:0] c, input logic swap);
        return swap ? swap16(c) : c;
    endfunction

    function automatic logic [3:0] shade4(input logic [3:0] c);
        logic [11:0] prod;
        prod = {8'd0, c} * SHADE_MUL;
        return prod[11:8];
    endfunction

    function automatic logic [15:0] pack565(input logic [3:0] r4, input logic [3:0] g4,
                                            input logic [3:0] b4);
        return {r4, r4[3], g4, g4[3:2], b4, b4[3]};
    endfunction

endpackage

`default_nettype wire

/* rtl/plsb_front.sv */
// Front end: accepts item words, drops ignored ones, decodes selectors and
// builds colors. Depends on plsb_pkg.
`default_nettype none

module plsb_front #(
    parameter int PALETTE_ENTRIES = 4096
) (
    input  wire plsb_pkg::item_word_t item,
    input  wire                       item_valid,
    input  wire                       queue_full,
    input  wire                       swap,
    output logic                      push,
    output plsb_pkg::op_t             op
);

    localparam int TABLE_DEPTH = 3 * PALETTE_ENTRIES;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int OFF_W       = $clog2(PALETTE_ENTRIES);
    localparam int OFF_MAX_W   = plsb_pkg::OFF_MAX_W;
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W:0]   LIM1     = (IDX_W + 1)'(PALETTE_ENTRIES);
    localparam logic [IDX_W:0]   LIM2     = (IDX_W + 1)'(2 * PALETTE_ENTRIES);
    localparam logic [IDX_W:0]   LIM3     = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [13:0]      WR_LIM   = 14'(PALETTE_ENTRIES);

    function automatic plsb_pkg::lane_t decode(input logic [15:0] sel);
        plsb_pkg::lane_t l;
        logic [IDX_W:0]  idx;
        logic [IDX_W:0]  rel;
        idx = {1'b0, sel[IDX_W-1:0] & IDX_MASK};
        l.hit = idx < LIM3;
        if (idx >= LIM2)
        begin
            l.bank = plsb_pkg::BANK_HIGHLIGHT;
            rel    = idx - LIM2;
        end
        else if (idx >= LIM1)
        begin
            l.bank = plsb_pkg::BANK_SHADOW;
            rel    = idx - LIM1;
        end
        else
        begin
            l.bank = plsb_pkg::BANK_NORMAL;
            rel    = idx;
        end
        l.off = OFF_MAX_W'(rel[OFF_W-1:0]);
        return l;
    endfunction

    logic [13:0] wr_idx;
    logic        wr_ok;
    logic [3:0]  r4, g4, b4;
    logic [15:0] c_in;
    logic [3:0]  cr4, cg4, cb4;
    logic [15:0] wr_shadow;
    logic [15:0] px_shadow;
    logic        keep;

    always_comb
    begin
        wr_idx    = {1'b0, item.pal_byte_addr[13:1]};
        wr_ok     = wr_idx < WR_LIM;
        r4        = item.red[4:1];
        g4        = item.green[4:1];
        b4        = item.blue[4:1];
        c_in      = plsb_pkg::to_order(item.color_in, swap);
        cr4       = c_in[15:12];
        cg4       = c_in[10:7];
        cb4       = c_in[4:1];
        wr_shadow = plsb_pkg::to_order(plsb_pkg::pack565(plsb_pkg::shade4(r4),
                        plsb_pkg::shade4(g4), plsb_pkg::shade4(b4)), swap);
        px_shadow = plsb_pkg::to_order(plsb_pkg::pack565(plsb_pkg::shade4(cr4),
                        plsb_pkg::shade4(cg4), plsb_pkg::shade4(cb4)), swap);

        case (item.func)
            plsb_pkg::FUNC_WRITE:   keep = wr_ok;
            plsb_pkg::FUNC_CONVERT: keep = 1'b1;
            plsb_pkg::FUNC_SHADE:   keep = 1'b1;
            default:                keep = 1'b0;
        endcase

        push      = item_valid && !queue_full && keep;
        op.kind   = item.func;
        op.wr_off = OFF_MAX_W'(wr_idx[OFF_W-1:0]);
        op.normal = plsb_pkg::to_order(plsb_pkg::pack565(r4, g4, b4), swap);
        op.shadow = (item.func == plsb_pkg::FUNC_SHADE) ? px_shadow : wr_shadow;
        op.lane0  = decode(item.selector_pair[15:0]);
        op.lane1  = decode(item.selector_pair[31:16]);
        op.last   = item.last_pair;
    end

endmodule

`default_nettype wire

/* rtl/plsb_queue.sv */
// Short operation queue between front and back ends.
// Depends on plsb_pkg.
`default_nettype none

module plsb_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire plsb_pkg::op_t push_op,
    input  wire                pop,
    output logic               full,
    output logic               not_empty,
    output plsb_pkg::op_t      head
);

    localparam int DEPTH = plsb_pkg::QUEUE_DEPTH;
    localparam int PW    = plsb_pkg::QPTR_W;

    plsb_pkg::op_t  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;

    always_comb
    begin
        full        = count_reg == (PW + 1)'(DEPTH);
        not_empty   = count_reg != '0;
        head        = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW + 1)'(push) - (PW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

/* rtl/plsb_back.sv */
// Back end: normal and shadow color memories, lookup stage and result
// register. Depends on plsb_pkg.
`default_nettype none

module plsb_back #(
    parameter int PALETTE_ENTRIES = 4096
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          head_valid,
    input  wire plsb_pkg::op_t           head,
    output logic                         pop,
    output plsb_pkg::result_word_t       result,
    output logic                         result_valid,
    input  wire                          result_stall
);

    localparam int OFF_W = $clog2(PALETTE_ENTRIES);

    logic [15:0] normal_mem [PALETTE_ENTRIES];
    logic [15:0] shadow_mem [PALETTE_ENTRIES];

    logic [15:0] rd0_n_reg, rd0_s_reg, rd1_n_reg, rd1_s_reg;
    logic        a_valid_reg, a_valid_next;
    logic [1:0]  a_kind_reg;
    logic        a_hit0_reg, a_hit1_reg;
    logic [1:0]  a_bank0_reg, a_bank1_reg;
    logic [15:0] a_shadow_reg;
    logic        a_last_reg;
    logic        out_valid_reg, out_valid_next;
    plsb_pkg::result_word_t out_reg;

    logic        a_advance;
    logic        has_result;
    logic [15:0] pix0, pix1;
    plsb_pkg::result_word_t a_word;

    always_comb
    begin
        a_advance  = !out_valid_reg || !result_stall;
        pop        = head_valid && (!a_valid_reg || a_advance);
        has_result = head.kind != plsb_pkg::FUNC_WRITE;

        if (pop)
            a_valid_next = has_result;
        else if (a_advance)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;

        if (a_valid_reg && a_advance)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        pix0 = !a_hit0_reg ? 16'd0 :
               (a_bank0_reg == plsb_pkg::BANK_NORMAL) ? rd0_n_reg : rd0_s_reg;
        pix1 = !a_hit1_reg ? 16'd0 :
               (a_bank1_reg == plsb_pkg::BANK_NORMAL) ? rd1_n_reg : rd1_s_reg;

        if (a_kind_reg == plsb_pkg::FUNC_CONVERT)
        begin
            a_word.pixel_pair = {pix1, pix0};
            a_word.pair_last  = a_last_reg;
        end
        else
        begin
            a_word.pixel_pair = {16'd0, a_shadow_reg};
            a_word.pair_last  = 1'b0;
        end

        result       = out_reg;
        result_valid = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.kind == plsb_pkg::FUNC_WRITE)
        begin
            normal_mem[head.wr_off[OFF_W-1:0]] <= head.normal;
            shadow_mem[head.wr_off[OFF_W-1:0]] <= head.shadow;
        end
        if (pop && has_result)
        begin
            rd0_n_reg    <= normal_mem[head.lane0.off[OFF_W-1:0]];
            rd0_s_reg    <= shadow_mem[head.lane0.off[OFF_W-1:0]];
            rd1_n_reg    <= normal_mem[head.lane1.off[OFF_W-1:0]];
            rd1_s_reg    <= shadow_mem[head.lane1.off[OFF_W-1:0]];
            a_kind_reg   <= head.kind;
            a_hit0_reg   <= head.lane0.hit;
            a_hit1_reg   <= head.lane1.hit;
            a_bank0_reg  <= head.lane0.bank;
            a_bank1_reg  <= head.lane1.bank;
            a_shadow_reg <= head.shadow;
            a_last_reg   <= head.last;
        end
        if (a_valid_reg && a_advance)
        begin
            out_reg <= a_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/palette_lookup_with_shadow_banks.sv */
// Top level of the three-bank RGB565 palette lookup block.
// Depends on plsb_pkg, plsb_front, plsb_queue and plsb_back.
//
//   channel   direction  handshake               word
//   item      in         item_valid/item_stall   plsb_pkg::item_word_t
//   result    out        result_valid/result_stall plsb_pkg::result_word_t
//   config    in         cfg_wr_en               cfg_wr_data (swap_bytes)
//
// One item per cycle sustained while item_stall is low; a result passes the queue
// slot, memory read stage and result register after its item is accepted.
// Reset clears swap_bytes, the queue and the stage valids; color memories are
// not cleared.
// item_stall rises only when the four-entry queue is full; result_stall holds
// the result register, then the read stage, then backs up into the queue.
`default_nettype none

module palette_lookup_with_shadow_banks #(
    parameter int PALETTE_ENTRIES = 4096
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          item_valid,
    output logic                         item_stall,
    input  wire plsb_pkg::item_word_t    item,
    output logic                         result_valid,
    input  wire                          result_stall,
    output plsb_pkg::result_word_t       result,
    input  wire                          cfg_wr_en,
    input  wire                          cfg_wr_data
);

    logic          swap_reg;
    logic          push;
    logic          pop;
    logic          full;
    logic          not_empty;
    plsb_pkg::op_t push_op;
    plsb_pkg::op_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            swap_reg <= 1'b0;
        else if (cfg_wr_en)
            swap_reg <= cfg_wr_data;
    end

    assign item_stall = full;

    plsb_front #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_front (
        .item       (item),
        .item_valid (item_valid),
        .queue_full (full),
        .swap       (swap_reg),
        .push       (push),
        .op         (push_op)
    );

    plsb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    plsb_back #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (not_empty),
        .head         (head),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire

/* rtl/plsb_checker.sv */
// Port-level checks for the palette lookup block, bound to the top level.
// Depends on plsb_pkg.
`default_nettype none

module plsb_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          item_valid,
    input wire                          item_stall,
    input wire                          result_valid,
    input wire                          result_stall,
    input wire plsb_pkg::result_word_t  result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_stall_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(item_valid && !item_stall))
        else $error("item_stall rose with no word accepted");

    a_reset_empty: assert property (@(posedge clk)
        rst_n && $past(!rst_n) |-> !item_stall && !result_valid)
        else $error("block not empty after reset");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(rst_n, 3))
        else $error("result appeared too soon after reset");

endmodule

bind palette_lookup_with_shadow_banks plsb_checker u_plsb_checker (.*);

`default_nettype wire

/* tb/sv/palette_lookup_with_shadow_banks_tb.sv */
// Self-checking testbench for palette_lookup_with_shadow_banks: palette writes,
// pixel-pair lookups and shadow colors checked against an in-bench color model.
// Depends on plsb_pkg and the RTL of the block.
`timescale 1ns / 100ps

module palette_lookup_with_shadow_banks_tb;

    localparam int PE           = 4096;
    localparam int TABLE_DEPTH  = 3 * PE;
    localparam logic [15:0] SEL_MASK = 16'(TABLE_DEPTH - 1);
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    plsb_pkg::item_word_t   item_bus = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    plsb_pkg::result_word_t result_bus;
    logic                   cfg_wr_en = 1'b0;
    logic                   cfg_wr_data = 1'b0;

    logic [15:0]            palette_mem [TABLE_DEPTH];
    logic                   swap_now = 1'b0;
    plsb_pkg::result_word_t pixels_due [$];
    plsb_pkg::item_word_t   items_to_send [$];
    int                     written_list [$];
    bit                     entry_seen [PE];
    int                     last_written = 0;

    logic         item_fired = 1'b0;
    int           queued_count = 0;
    int           accepted_count = 0;
    int           results_seen = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_gap = 0;
    int           send_calm = 0;
    int           stall_left = 0;
    int           recv_calm = 0;
    int           hold_left = 0;
    int           holds_done = 0;

    palette_lookup_with_shadow_banks #(
        .PALETTE_ENTRIES(PE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item_bus),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result_bus),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] in_order(input logic [15:0] c);
        return swap_now ? {c[7:0], c[15:8]} : c;
    endfunction

    function automatic logic [3:0] dim4(input logic [3:0] c);
        int scaled;
        scaled = (int'(c) * 202) / 256;
        return 4'(scaled);
    endfunction

    function automatic logic [15:0] rgb565(input logic [3:0] r4, input logic [3:0] g4,
                                           input logic [3:0] b4);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = {r4, r4[3]};
        g6 = {g4, g4[3:2]};
        b5 = {b4, b4[3]};
        return {r5, g6, b5};
    endfunction

    function automatic bit lookup_step(input plsb_pkg::item_word_t w,
                                       output plsb_pkg::result_word_t r);
        logic [12:0] slot;
        logic [15:0] c;
        logic [15:0] lo;
        logic [15:0] hi;
        bit          produced;
        r = '0;
        produced = 1'b0;
        case (w.func)
            plsb_pkg::FUNC_WRITE:
            begin
                slot = w.pal_byte_addr[13:1];
                if (int'(slot) < PE)
                begin
                    palette_mem[slot] = in_order(rgb565(w.red[4:1], w.green[4:1], w.blue[4:1]));
                    c = in_order(rgb565(dim4(w.red[4:1]), dim4(w.green[4:1]),
                                        dim4(w.blue[4:1])));
                    palette_mem[int'(slot) + PE] = c;
                    palette_mem[int'(slot) + 2 * PE] = c;
                end
            end
            plsb_pkg::FUNC_CONVERT:
            begin
                lo = palette_mem[w.selector_pair[15:0] & SEL_MASK];
                hi = palette_mem[w.selector_pair[31:16] & SEL_MASK];
                r.pixel_pair = {hi, lo};
                r.pair_last = w.last_pair;
                produced = 1'b1;
            end
            plsb_pkg::FUNC_SHADE:
            begin
                c = in_order(w.color_in);
                r.pixel_pair = {16'd0, in_order(rgb565(dim4(c[15:12]), dim4(c[10:7]),
                                                        dim4(c[4:1])))};
                r.pair_last = 1'b0;
                produced = 1'b1;
            end
            default:
                produced = 1'b0;
        endcase
        return produced;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_selector();
        int          n;
        logic [15:0] s;
        if ($urandom_range(0, 3) == 0)
            n = last_written;
        else
            n = written_list[$urandom_range(0, written_list.size() - 1)];
        s = 16'(n);
        if ($urandom_range(0, 1) == 1)
            s = s + 16'(2 * PE);
        return s | (16'($urandom) & ~SEL_MASK);
    endfunction

    task automatic queue_item(input plsb_pkg::item_word_t w);
        int slot;
        if (w.func == plsb_pkg::FUNC_WRITE && w.pal_byte_addr[13] == 1'b0)
        begin
            slot = int'(w.pal_byte_addr[13:1]);
            if (!entry_seen[slot])
                written_list.push_back(slot);
            entry_seen[slot] = 1'b1;
            last_written = slot;
        end
        items_to_send.push_back(w);
        queued_count++;
    endtask

    task automatic queue_directed(input logic [1:0] f, input logic [13:0] addr,
                                  input logic [4:0] r, input logic [4:0] g, input logic [4:0] b,
                                  input logic [31:0] sel, input logic [15:0] color,
                                  input logic last);
        plsb_pkg::item_word_t w;
        w.func = f;
        w.pal_byte_addr = addr;
        w.red = r;
        w.green = g;
        w.blue = b;
        w.selector_pair = sel;
        w.color_in = color;
        w.last_pair = last;
        queue_item(w);
    endtask

    task automatic queue_random();
        plsb_pkg::item_word_t w;
        int                   r;
        w.pal_byte_addr = 14'($urandom);
        w.red = 5'($urandom);
        w.green = 5'($urandom);
        w.blue = 5'($urandom);
        w.selector_pair = $urandom;
        w.color_in = 16'($urandom);
        w.last_pair = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            w.func = plsb_pkg::FUNC_WRITE;
            if ($urandom_range(0, 9) != 0)
                w.pal_byte_addr[13] = 1'b0;
        end
        else if (r < 75)
        begin
            w.func = plsb_pkg::FUNC_CONVERT;
            w.selector_pair = {pick_selector(), pick_selector()};
        end
        else if (r < 95)
            w.func = plsb_pkg::FUNC_SHADE;
        else
            w.func = FUNC_UNUSED;
        queue_item(w);
    endtask

    task automatic write_swap(input logic value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_count != queued_count || pixels_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // sender: advance to the next word once the current one is taken
    always @(negedge clk)
    begin
        if (!item_valid || item_fired)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (items_to_send.size() > 0)
            begin
                item_bus <= items_to_send.pop_front();
                item_valid <= 1'b1;
                if (send_calm > 0)
                    send_calm--;
                else if ($urandom_range(0, 49) == 0)
                    send_calm = 80;
                else
                    send_gap = pick_len();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus long holds to back the block up
    always @(negedge clk)
    begin
        if (hold_left == 0 && holds_done < 2 && results_seen >= 60 + 340 * holds_done)
        begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            if (recv_calm > 0)
                recv_calm--;
            else if ($urandom_range(0, 59) == 0)
                recv_calm = 80;
            else
                stall_left = pick_len();
        end
    end

    always @(posedge clk)
    begin
        plsb_pkg::result_word_t want;
        plsb_pkg::result_word_t oldest;
        if (rst_n)
        begin
            if (cfg_wr_en)
                swap_now = cfg_wr_data;
            item_fired <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                accepted_count++;
                if (lookup_step(item_bus, want))
                    pixels_due.push_back(want);
            end
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (pixels_due.size() == 0)
                begin
                    $display("%0t: unexpected word, got pixel_pair %h pair_last %b",
                             $time, result_bus.pixel_pair, result_bus.pair_last);
                    mismatch_count++;
                end
                else
                begin
                    oldest = pixels_due.pop_front();
                    if (result_bus.pixel_pair !== oldest.pixel_pair)
                    begin
                        $display("%0t: pixel_pair expected %h got %h",
                                 $time, oldest.pixel_pair, result_bus.pixel_pair);
                        mismatch_count++;
                    end
                    if (result_bus.pair_last !== oldest.pair_last)
                    begin
                        $display("%0t: pair_last expected %b got %b",
                                 $time, oldest.pair_last, result_bus.pair_last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic swap_plan [6];
        swap_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_swap(1'b0);

        queue_directed(plsb_pkg::FUNC_WRITE, 14'd0, 5'd0, 5'd0, 5'd0,
                       32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        queue_directed(plsb_pkg::FUNC_WRITE, 14'd8191, 5'd31, 5'd31, 5'd31,
                       32'h0, 16'h0, 1'b0);
        queue_directed(plsb_pkg::FUNC_WRITE, 14'd8192, 5'd31, 5'd31, 5'd31,
                       32'h0, 16'h0, 1'b0);
        queue_directed(plsb_pkg::FUNC_WRITE, 14'd16383, 5'd0, 5'd0, 5'd0,
                       32'h0, 16'h0, 1'b1);
        queue_directed(plsb_pkg::FUNC_WRITE, 14'd2, 5'd31, 5'd0, 5'd16,
                       32'h0, 16'h0, 1'b0);
        queue_directed(plsb_pkg::FUNC_CONVERT, 14'd0, 5'd0, 5'd0, 5'd0,
                       32'hFFFF_0000, 16'h0, 1'b1);
        queue_directed(plsb_pkg::FUNC_CONVERT, 14'd0, 5'd0, 5'd0, 5'd0,
                       32'h2000_D001, 16'h0, 1'b0);
        queue_directed(plsb_pkg::FUNC_CONVERT, 14'd0, 5'd0, 5'd0, 5'd0,
                       32'h2FFF_2001, 16'h0, 1'b1);
        queue_directed(plsb_pkg::FUNC_SHADE, 14'd0, 5'd0, 5'd0, 5'd0,
                       32'h0, 16'h0000, 1'b1);
        queue_directed(plsb_pkg::FUNC_SHADE, 14'd0, 5'd0, 5'd0, 5'd0,
                       32'h0, 16'hFFFF, 1'b1);
        queue_directed(plsb_pkg::FUNC_SHADE, 14'd0, 5'd0, 5'd0, 5'd0,
                       32'h0, 16'h8410, 1'b0);
        queue_directed(plsb_pkg::FUNC_SHADE, 14'd0, 5'd0, 5'd0, 5'd0,
                       32'h0, 16'h7BEF, 1'b0);
        queue_directed(FUNC_UNUSED, 14'd6, 5'd9, 5'd9, 5'd9, 32'h0000_0001, 16'h1234, 1'b1);
        queue_directed(plsb_pkg::FUNC_WRITE, 14'd4, 5'd17, 5'd9, 5'd30,
                       32'h0, 16'h0, 1'b0);
        queue_directed(plsb_pkg::FUNC_CONVERT, 14'd0, 5'd0, 5'd0, 5'd0,
                       32'h2002_0002, 16'h0, 1'b0);
        queue_directed(plsb_pkg::FUNC_WRITE, 14'd5, 5'd1, 5'd2, 5'd3,
                       32'h0, 16'h0, 1'b1);
        queue_directed(plsb_pkg::FUNC_CONVERT, 14'd0, 5'd0, 5'd0, 5'd0,
                       32'hF002_D002, 16'h0, 1'b1);
        wait_drained();

        foreach (swap_plan[p])
        begin
            write_swap(swap_plan[p]);
            repeat (ITEMS_PER_PHASE) queue_random();
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
